[rtl/fdr_pkg.sv]
package fdr_pkg;

    // Q3.12 one, the outside index
    localparam logic [14:0] ETA_ONE = 15'd4096;

    // Q2.28 one, clamp bound for the dot product
    localparam logic signed [33:0] DOT_ONE = 34'sd268435456;

    // Q0.32 one
    localparam logic [33:0] UNIT_Q32 = 34'h1_0000_0000;

    // Q0.16 one
    localparam logic [16:0] REFL_ONE = 17'd65536;

    // geometry carried alongside the long arithmetic chains
    typedef struct packed {
        logic        tir;
        logic [14:0] eta_i;
        logic [14:0] eta_t;
        logic [16:0] cos_i;
    } fdr_geom_t;

endpackage

[rtl/fresnel_dielectric_reflectance.sv]
// Unpolarized Fresnel reflectance of a dielectric boundary.
// Input channel (in_valid/in_ready): one request carries the incident
// direction and surface normal (signed Q1.14) and the refractive index
// (unsigned Q3.12). Output channel (out_valid/out_ready): reflectance in
// Q0.16 (65536 is one) and the total internal reflection flag.
// The datapath is one long pipeline: five stages for the dot product,
// index swap and sin^2 of incidence, a 32-cell restoring divider for
// sin^2 of transmission, a 17-cell square root for cosT, two stages for
// the amplitude terms, two 17-cell dividers in parallel for the s and p
// ratios, one squaring stage and the output register.
// Throughput is one request per cycle while out_ready does not stall the
// pipeline, set by the cell rows, each of which hands one partial result
// to its neighbor every cycle that the pipeline is enabled.
// Reset clears all valid bits; the pipeline comes up empty.
// When the receiver stalls with a result waiting, the whole pipeline
// holds (in_ready follows out_ready while out_valid is high); nothing
// in flight is lost or duplicated.
module fresnel_dielectric_reflectance (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] incident_x,
    input  logic [15:0] incident_y,
    input  logic [15:0] incident_z,
    input  logic [15:0] normal_x,
    input  logic [15:0] normal_y,
    input  logic [15:0] normal_z,
    input  logic [14:0] refractive_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [16:0] reflectance,
    output logic        total_reflection
);

    import fdr_pkg::*;

    logic en;

    // stage A: component products
    logic               a_vld_reg;
    logic signed [31:0] a_px_reg, a_py_reg, a_pz_reg;
    logic        [14:0] a_ior_reg;

    // stage B: dot, clamp, swap, cosI
    logic signed [33:0] b_dot, b_clamp;
    logic        [28:0] b_mag;
    logic               b_vld_reg;
    logic        [16:0] b_cosi_reg, b_cosi_next;
    logic        [14:0] b_etai_reg, b_etai_next, b_etat_reg, b_etat_next;

    // stage C: sin^2 of incidence, squared indices
    logic        c_vld_reg;
    logic [33:0] c_cos_sq;
    logic [32:0] c_sini2_reg;
    logic [29:0] c_ei2_reg, c_et2_reg;
    logic [16:0] c_cosi_reg;
    logic [14:0] c_etai_reg, c_etat_reg;

    // stage D: partial products of etaI^2 * sinI^2
    logic        d_vld_reg;
    logic [45:0] d_lo_reg;
    logic [46:0] d_hi_reg;
    logic [29:0] d_et2_reg;
    logic [16:0] d_cosi_reg;
    logic [14:0] d_etai_reg, d_etat_reg;

    // stage E: full numerator and the total reflection test
    logic        e_vld_reg;
    logic [62:0] e_num_reg, e_num_next;
    logic [29:0] e_et2_reg;
    fdr_geom_t   e_geom_reg, e_geom_next;

    // divider and root chains
    logic        dv_vld;
    logic [31:0] dv_sint2;
    fdr_geom_t   dv_geom;
    logic [33:0] cost2;
    logic        sq_vld;
    logic [16:0] sq_cost;
    fdr_geom_t   sq_geom;

    // stage G: amplitude terms
    logic        g_vld_reg;
    logic [31:0] g_ps_reg, g_qs_reg, g_pp_reg, g_qp_reg;
    logic        g_tir_reg;

    // stage H: ratio numerators and denominators
    logic        h_vld_reg;
    logic [32:0] h_dens_reg, h_dens_next, h_denp_reg, h_denp_next;
    logic [31:0] h_diffs_next, h_diffp_next;
    logic [47:0] h_nums_reg, h_nump_reg;
    logic        h_tir_reg;

    // ratio chains
    logic        rs_vld, rp_vld;
    logic [16:0] rs_q, rp_q;
    logic [1:0]  rs_side;
    logic [0:0]  rp_side;

    // stage I: squared ratios
    logic        i_vld_reg;
    logic [33:0] i_sqs_reg, i_sqp_reg;
    logic        i_tir_reg, i_zs_reg, i_zp_reg;

    // output register
    logic        o_vld_reg;
    logic [16:0] o_refl_reg, o_refl_next;
    logic        o_tir_reg;
    logic [17:0] rs2, rp2;

    // single stall for the whole pipeline
    assign en       = !o_vld_reg || out_ready;
    assign in_ready = en;

    // ---------------- stage A ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
            g_vld_reg <= 1'b0;
            h_vld_reg <= 1'b0;
            i_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg <= in_valid;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= c_vld_reg;
            e_vld_reg <= d_vld_reg;
            g_vld_reg <= sq_vld;
            h_vld_reg <= g_vld_reg;
            i_vld_reg <= rs_vld && rp_vld;
            o_vld_reg <= i_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_px_reg  <= $signed(incident_x) * $signed(normal_x);
            a_py_reg  <= $signed(incident_y) * $signed(normal_y);
            a_pz_reg  <= $signed(incident_z) * $signed(normal_z);
            a_ior_reg <= refractive_index;
        end
    end

    // ---------------- stage B ----------------
    always_comb
    begin
        b_dot = 34'(a_px_reg) + 34'(a_py_reg) + 34'(a_pz_reg);
        if (b_dot > DOT_ONE)
        begin
            b_clamp = DOT_ONE;
        end
        else if (b_dot < -DOT_ONE)
        begin
            b_clamp = -DOT_ONE;
        end
        else
        begin
            b_clamp = b_dot;
        end
        b_mag       = (b_clamp < 0) ? 29'(-b_clamp) : 29'(b_clamp);
        b_cosi_next = 17'((30'(b_mag) + 30'd2048) >> 12);
        // leaving the medium: indices swap
        if (b_clamp > 0)
        begin
            b_etai_next = a_ior_reg;
            b_etat_next = ETA_ONE;
        end
        else
        begin
            b_etai_next = ETA_ONE;
            b_etat_next = a_ior_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_cosi_reg <= b_cosi_next;
            b_etai_reg <= b_etai_next;
            b_etat_reg <= b_etat_next;
        end
    end

    // ---------------- stage C ----------------
    assign c_cos_sq = 34'(b_cosi_reg) * 34'(b_cosi_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_sini2_reg <= 33'(UNIT_Q32 - c_cos_sq);
            c_ei2_reg   <= 30'(b_etai_reg) * 30'(b_etai_reg);
            c_et2_reg   <= 30'(b_etat_reg) * 30'(b_etat_reg);
            c_cosi_reg  <= b_cosi_reg;
            c_etai_reg  <= b_etai_reg;
            c_etat_reg  <= b_etat_reg;
        end
    end

    // ---------------- stage D ----------------
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_lo_reg   <= 46'(c_ei2_reg) * 46'(c_sini2_reg[15:0]);
            d_hi_reg   <= 47'(c_ei2_reg) * 47'(c_sini2_reg[32:16]);
            d_et2_reg  <= c_et2_reg;
            d_cosi_reg <= c_cosi_reg;
            d_etai_reg <= c_etai_reg;
            d_etat_reg <= c_etat_reg;
        end
    end

    // ---------------- stage E ----------------
    always_comb
    begin
        e_num_next        = (63'(d_hi_reg) << 16) + 63'(d_lo_reg);
        // sinT >= 1: etaI^2 sinI^2 >= etaT^2
        e_geom_next.tir   = e_num_next >= {1'b0, d_et2_reg, 32'd0};
        e_geom_next.eta_i = d_etai_reg;
        e_geom_next.eta_t = d_etat_reg;
        e_geom_next.cos_i = d_cosi_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_num_reg  <= e_num_next;
            e_et2_reg  <= d_et2_reg;
            e_geom_reg <= e_geom_next;
        end
    end

    // sinT^2 = etaI^2 sinI^2 / etaT^2, Q0.32
    fdr_div_chain #(
        .NW(63),
        .DW(30),
        .QW(32),
        .SW($bits(fdr_geom_t))
    ) u_sint_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld_in  (e_vld_reg),
        .num_in  (e_num_reg),
        .div_in  (e_et2_reg),
        .side_in (e_geom_reg),
        .vld_out (dv_vld),
        .q_out   (dv_sint2),
        .side_out(dv_geom)
    );

    assign cost2 = UNIT_Q32 - 34'(dv_sint2);

    // cosT = floor(sqrt(1 - sinT^2)), Q0.16
    fdr_sqrt_chain #(
        .RW(17),
        .SW($bits(fdr_geom_t))
    ) u_cost_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld_in  (dv_vld),
        .val_in  (cost2),
        .side_in (dv_geom),
        .vld_out (sq_vld),
        .root_out(sq_cost),
        .side_out(sq_geom)
    );

    // ---------------- stage G ----------------
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_ps_reg  <= 32'(sq_geom.eta_t) * 32'(sq_geom.cos_i);
            g_qs_reg  <= 32'(sq_geom.eta_i) * 32'(sq_cost);
            g_pp_reg  <= 32'(sq_geom.eta_i) * 32'(sq_geom.cos_i);
            g_qp_reg  <= 32'(sq_geom.eta_t) * 32'(sq_cost);
            g_tir_reg <= sq_geom.tir;
        end
    end

    // ---------------- stage H ----------------
    always_comb
    begin
        h_dens_next  = 33'(g_ps_reg) + 33'(g_qs_reg);
        h_denp_next  = 33'(g_pp_reg) + 33'(g_qp_reg);
        h_diffs_next = (g_ps_reg >= g_qs_reg) ? g_ps_reg - g_qs_reg : g_qs_reg - g_ps_reg;
        h_diffp_next = (g_pp_reg >= g_qp_reg) ? g_pp_reg - g_qp_reg : g_qp_reg - g_pp_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_dens_reg <= h_dens_next;
            h_denp_reg <= h_denp_next;
            h_nums_reg <= {h_diffs_next, 16'd0};
            h_nump_reg <= {h_diffp_next, 16'd0};
            h_tir_reg  <= g_tir_reg;
        end
    end

    // s and p amplitude ratios, Q0.16
    fdr_div_chain #(
        .NW(48),
        .DW(33),
        .QW(17),
        .SW(2)
    ) u_rs_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld_in  (h_vld_reg),
        .num_in  (h_nums_reg),
        .div_in  (h_dens_reg),
        .side_in ({h_tir_reg, h_dens_reg == '0}),
        .vld_out (rs_vld),
        .q_out   (rs_q),
        .side_out(rs_side)
    );

    fdr_div_chain #(
        .NW(48),
        .DW(33),
        .QW(17),
        .SW(1)
    ) u_rp_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld_in  (h_vld_reg),
        .num_in  (h_nump_reg),
        .div_in  (h_denp_reg),
        .side_in (h_denp_reg == '0),
        .vld_out (rp_vld),
        .q_out   (rp_q),
        .side_out(rp_side)
    );

    // ---------------- stage I ----------------
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            i_sqs_reg <= 34'(rs_q) * 34'(rs_q);
            i_sqp_reg <= 34'(rp_q) * 34'(rp_q);
            i_tir_reg <= rs_side[1];
            i_zs_reg  <= rs_side[0];
            i_zp_reg  <= rp_side[0];
        end
    end

    // ---------------- output register ----------------
    always_comb
    begin
        // zero denominator is the grazing limit: squared ratio of one
        rs2 = i_zs_reg ? 18'(REFL_ONE) : 18'((i_sqs_reg + 34'd32768) >> 16);
        rp2 = i_zp_reg ? 18'(REFL_ONE) : 18'((i_sqp_reg + 34'd32768) >> 16);
        if (i_tir_reg)
        begin
            o_refl_next = REFL_ONE;
        end
        else
        begin
            o_refl_next = 17'((19'(rs2) + 19'(rp2) + 19'd1) >> 1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_refl_reg <= o_refl_next;
            o_tir_reg  <= i_tir_reg;
        end
    end

    assign out_valid        = o_vld_reg;
    assign reflectance      = o_refl_reg;
    assign total_reflection = o_tir_reg;

endmodule

[rtl/fdr_div_cell.sv]
module fdr_div_cell #(
    parameter int CW = 63,
    parameter int DW = 30,
    parameter int QW = 32,
    parameter int B  = 0,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          vld_in,
    input  logic [CW-1:0] rem_in,
    input  logic [DW-1:0] div_in,
    input  logic [QW-1:0] q_in,
    input  logic [SW-1:0] side_in,
    output logic          vld_out,
    output logic [CW-1:0] rem_out,
    output logic [DW-1:0] div_out,
    output logic [QW-1:0] q_out,
    output logic [SW-1:0] side_out
);

    logic          vld_reg;
    logic [CW-1:0] rem_reg, rem_next;
    logic [DW-1:0] div_reg;
    logic [QW-1:0] q_reg, q_next;
    logic [SW-1:0] side_reg;
    logic [CW-1:0] trial;
    logic          take;

    // one restoring step: quotient bit B
    always_comb
    begin
        trial    = CW'(div_in) << B;
        take     = rem_in >= trial;
        rem_next = take ? rem_in - trial : rem_in;
        q_next   = q_in | (take ? (QW'(1) << B) : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            div_reg  <= div_in;
            q_reg    <= q_next;
            side_reg <= side_in;
        end
    end

    assign vld_out  = vld_reg;
    assign rem_out  = rem_reg;
    assign div_out  = div_reg;
    assign q_out    = q_reg;
    assign side_out = side_reg;

endmodule

[rtl/fdr_div_chain.sv]
module fdr_div_chain #(
    parameter int NW = 63,
    parameter int DW = 30,
    parameter int QW = 32,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          vld_in,
    input  logic [NW-1:0] num_in,
    input  logic [DW-1:0] div_in,
    input  logic [SW-1:0] side_in,
    output logic          vld_out,
    output logic [QW-1:0] q_out,
    output logic [SW-1:0] side_out
);

    localparam int CW = (NW > DW + QW) ? NW : DW + QW;

    logic          vld_w  [QW+1];
    logic [CW-1:0] rem_w  [QW+1];
    logic [DW-1:0] div_w  [QW+1];
    logic [QW-1:0] q_w    [QW+1];
    logic [SW-1:0] side_w [QW+1];

    assign vld_w[0]  = vld_in;
    assign rem_w[0]  = CW'(num_in);
    assign div_w[0]  = div_in;
    assign q_w[0]    = '0;
    assign side_w[0] = side_in;

    // cell k settles quotient bit QW-1-k
    for (genvar k = 0; k < QW; k++)
    begin : g_cell
        fdr_div_cell #(
            .CW(CW),
            .DW(DW),
            .QW(QW),
            .B (QW - 1 - k),
            .SW(SW)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .vld_in  (vld_w[k]),
            .rem_in  (rem_w[k]),
            .div_in  (div_w[k]),
            .q_in    (q_w[k]),
            .side_in (side_w[k]),
            .vld_out (vld_w[k+1]),
            .rem_out (rem_w[k+1]),
            .div_out (div_w[k+1]),
            .q_out   (q_w[k+1]),
            .side_out(side_w[k+1])
        );
    end

    assign vld_out  = vld_w[QW];
    assign q_out    = q_w[QW];
    assign side_out = side_w[QW];

endmodule

[rtl/fdr_sqrt_cell.sv]
module fdr_sqrt_cell #(
    parameter int RW = 17,
    parameter int B  = 0,
    parameter int SW = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            vld_in,
    input  logic [2*RW-1:0] rem_in,
    input  logic [RW-1:0]   res_in,
    input  logic [SW-1:0]   side_in,
    output logic            vld_out,
    output logic [2*RW-1:0] rem_out,
    output logic [RW-1:0]   res_out,
    output logic [SW-1:0]   side_out
);

    localparam int CW = 2 * RW;

    logic          vld_reg;
    logic [CW-1:0] rem_reg, rem_next;
    logic [RW-1:0] res_reg, res_next;
    logic [SW-1:0] side_reg;
    logic [CW-1:0] trial;
    logic          take;

    // rem holds v - res^2; setting bit B adds res*2^(B+1) + 2^(2B)
    always_comb
    begin
        trial    = (CW'(res_in) << (B + 1)) | (CW'(1) << (2 * B));
        take     = rem_in >= trial;
        rem_next = take ? rem_in - trial : rem_in;
        res_next = res_in | (take ? (RW'(1) << B) : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            res_reg  <= res_next;
            side_reg <= side_in;
        end
    end

    assign vld_out  = vld_reg;
    assign rem_out  = rem_reg;
    assign res_out  = res_reg;
    assign side_out = side_reg;

endmodule

[rtl/fdr_sqrt_chain.sv]
module fdr_sqrt_chain #(
    parameter int RW = 17,
    parameter int SW = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            vld_in,
    input  logic [2*RW-1:0] val_in,
    input  logic [SW-1:0]   side_in,
    output logic            vld_out,
    output logic [RW-1:0]   root_out,
    output logic [SW-1:0]   side_out
);

    logic            vld_w  [RW+1];
    logic [2*RW-1:0] rem_w  [RW+1];
    logic [RW-1:0]   res_w  [RW+1];
    logic [SW-1:0]   side_w [RW+1];

    assign vld_w[0]  = vld_in;
    assign rem_w[0]  = val_in;
    assign res_w[0]  = '0;
    assign side_w[0] = side_in;

    for (genvar k = 0; k < RW; k++)
    begin : g_cell
        fdr_sqrt_cell #(
            .RW(RW),
            .B (RW - 1 - k),
            .SW(SW)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .vld_in  (vld_w[k]),
            .rem_in  (rem_w[k]),
            .res_in  (res_w[k]),
            .side_in (side_w[k]),
            .vld_out (vld_w[k+1]),
            .rem_out (rem_w[k+1]),
            .res_out (res_w[k+1]),
            .side_out(side_w[k+1])
        );
    end

    assign vld_out  = vld_w[RW];
    assign root_out = res_w[RW];
    assign side_out = side_w[RW];

endmodule

[tb/sv/fresnel_dielectric_reflectance_tb.sv]
`timescale 1ns / 100ps

// Scoreboard: predicts reflectance for each accepted request, checks results in order.
class fresnel_scoreboard;
    typedef struct {
        logic [16:0] refl;
        logic        tir;
    } refl_result_t;

    refl_result_t pending_q[$];
    int unsigned  err_count;
    int unsigned  checked;
    int unsigned  tir_seen;

    function new();
        err_count = 0;
        checked = 0;
        tir_seen = 0;
    endfunction

    static function longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    static function longint unsigned amp_ratio_sq(longint unsigned p, longint unsigned q);
        longint unsigned den;
        longint unsigned diff;
        longint unsigned r;
        den = p + q;
        diff = (p >= q) ? p - q : q - p;
        if (den == 0)
            return 64'd65536;
        r = (diff << 16) / den;
        return (r * r + 64'd32768) >> 16;
    endfunction

    function void note_request(logic signed [15:0] ix, logic signed [15:0] iy,
                               logic signed [15:0] iz, logic signed [15:0] nx,
                               logic signed [15:0] ny, logic signed [15:0] nz,
                               logic [14:0] ior);
        longint          d;
        longint unsigned eta_i;
        longint unsigned eta_t;
        longint unsigned mag;
        longint unsigned cos_i;
        longint unsigned sin_i2;
        longint unsigned num;
        longint unsigned den;
        longint unsigned sin_t2;
        longint unsigned cos_t;
        longint unsigned rs2;
        longint unsigned rp2;
        refl_result_t    res;
        d = longint'(ix) * nx + longint'(iy) * ny + longint'(iz) * nz;
        if (d > (64'sd1 <<< 28)) d = 64'sd1 <<< 28;
        if (d < -(64'sd1 <<< 28)) d = -(64'sd1 <<< 28);
        eta_i = fdr_pkg::ETA_ONE;
        eta_t = ior;
        if (d > 0)
        begin
            eta_i = ior;
            eta_t = fdr_pkg::ETA_ONE;
        end
        mag = (d < 0) ? -d : d;
        cos_i = (mag + 2048) >> 12;
        sin_i2 = (64'd1 << 32) - cos_i * cos_i;
        num = eta_i * eta_i * sin_i2;
        den = (eta_t * eta_t) << 32;
        if (num >= den)
        begin
            res.refl = fdr_pkg::REFL_ONE;
            res.tir = 1'b1;
        end
        else
        begin
            sin_t2 = num / (eta_t * eta_t);
            cos_t = int_sqrt((64'd1 << 32) - sin_t2);
            rs2 = amp_ratio_sq(eta_t * cos_i, eta_i * cos_t);
            rp2 = amp_ratio_sq(eta_i * cos_i, eta_t * cos_t);
            res.refl = 17'((rs2 + rp2 + 1) >> 1);
            res.tir = 1'b0;
        end
        pending_q.push_back(res);
    endfunction

    function void check_result(logic [16:0] refl, logic tir);
        refl_result_t exp_res;
        checked++;
        if (pending_q.size() == 0)
        begin
            $display("%0t: unexpected result refl=%0d tir=%0b", $time, refl, tir);
            err_count++;
            return;
        end
        exp_res = pending_q.pop_front();
        if (tir) tir_seen++;
        if (refl !== exp_res.refl)
        begin
            $display("%0t: reflectance expected %0d actual %0d", $time, exp_res.refl, refl);
            err_count++;
        end
        if (tir !== exp_res.tir)
        begin
            $display("%0t: total_reflection expected %0b actual %0b", $time,
                     exp_res.tir, tir);
            err_count++;
        end
    endfunction
endclass

module fresnel_dielectric_reflectance_tb;
    import fdr_pkg::*;

    // pipeline depth of the block, from acceptance to out_valid
    localparam int LATENCY      = 75;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 550;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [15:0] incident_x;
    logic [15:0] incident_y;
    logic [15:0] incident_z;
    logic [15:0] normal_x;
    logic [15:0] normal_y;
    logic [15:0] normal_z;
    logic [14:0] refractive_index;
    logic        out_valid;
    logic        out_ready;
    logic [16:0] reflectance;
    logic        total_reflection;

    fresnel_scoreboard sb;

    // idle percentages for sender and receiver, changed between phases
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    // long receiver hold-off, counted down by the receiver process
    int unsigned recv_hold;
    int unsigned cycle_count;

    fresnel_dielectric_reflectance dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .incident_x       (incident_x),
        .incident_y       (incident_y),
        .incident_z       (incident_z),
        .normal_x         (normal_x),
        .normal_y         (normal_y),
        .normal_z         (normal_z),
        .refractive_index (refractive_index),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .reflectance      (reflectance),
        .total_reflection (total_reflection)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Receiver: random stalls, or a long hold-off while recv_hold counts down.
    // Results are checked at the same edge the handshake completes.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_result(reflectance, total_reflection);
            if (recv_hold > 0)
            begin
                recv_hold <= recv_hold - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Run-length guard.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // One request: optional idle gap, then hold valid until the handshake.
    task automatic send_request(logic [15:0] ix, logic [15:0] iy, logic [15:0] iz,
                                logic [15:0] nx, logic [15:0] ny, logic [15:0] nz,
                                logic [14:0] ior);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid         <= 1'b1;
        incident_x       <= ix;
        incident_y       <= iy;
        incident_z       <= iz;
        normal_x         <= nx;
        normal_y         <= ny;
        normal_z         <= nz;
        refractive_index <= ior;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_request(ix, iy, iz, nx, ny, nz, ior);
        // valid is left high; the next call either refreshes payload or idles
    endtask

    task automatic go_idle();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Sender pause: wait until the scoreboard has drained.
    task automatic drain();
        go_idle();
        while (sb.pending_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [15:0] rand_comp();
        // mostly in range, sometimes anything
        if ($urandom_range(9) == 0)
            return 16'($urandom);
        return 16'($signed($urandom_range(32768)) - 16384);
    endfunction

    function automatic logic [14:0] rand_ior();
        case ($urandom_range(7))
            0:       return 15'($urandom);                      // full field
            1:       return 15'($urandom_range(255));           // below nominal range
            2:       return 15'($urandom_range(4096 + 300, 4096 - 300));
            default: return 15'($urandom_range(8192, 256));
        endcase
    endfunction

    // Random request, usually built as a near-unit pair at a chosen angle.
    task automatic send_random();
        logic [15:0] ix;
        logic [15:0] iy;
        logic [15:0] iz;
        logic [15:0] nx;
        logic [15:0] ny;
        logic [15:0] nz;
        real         th;
        real         ph;
        if ($urandom_range(3) == 0)
        begin
            ix = rand_comp(); iy = rand_comp(); iz = rand_comp();
            nx = rand_comp(); ny = rand_comp(); nz = rand_comp();
        end
        else
        begin
            th = $urandom_range(31416) / 10000.0;
            ph = $urandom_range(62832) / 10000.0;
            nx = 16'sd0; ny = 16'sd0;
            nz = ($urandom_range(1) != 0) ? 16'sd16384 : -16'sd16384;
            ix = 16'($rtoi(16384.0 * $sin(th) * $cos(ph)));
            iy = 16'($rtoi(16384.0 * $sin(th) * $sin(ph)));
            iz = 16'($rtoi(16384.0 * $cos(th)));
        end
        send_request(ix, iy, iz, nx, ny, nz, rand_ior());
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        incident_x = '0; incident_y = '0; incident_z = '0;
        normal_x = '0; normal_y = '0; normal_z = '0;
        refractive_index = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        recv_hold = 0;
        cycle_count = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: normal incidence from both sides, grazing, clamping,
        // zero index on each side, non-unit vectors, extremes of every field.
        send_request(16'sd16384, 0, 0, 16'sd16384, 0, 0, 15'd6144);
        send_request(-16'sd16384, 0, 0, 16'sd16384, 0, 0, 15'd6144);
        send_request(0, 16'sd16384, 0, 0, 0, 16'sd16384, 15'd6144);
        send_request(0, 16'sd16384, 0, 0, 0, 16'sd16384, 15'd2048);
        send_request(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                     15'd4096);
        send_request(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000,
                     15'h7FFF);
        send_request(16'sd16384, 0, 0, -16'sd16384, 0, 0, 15'd0);
        send_request(16'sd16384, 0, 0, 16'sd16384, 0, 0, 15'd0);
        send_request(16'sd11585, 0, 16'sd11585, 0, 0, 16'sd16384, 15'd2048);
        send_request(16'sd11585, 0, -16'sd11585, 0, 0, 16'sd16384, 15'd6144);
        send_request(0, 0, 0, 0, 0, 0, 15'd6144);
        send_request(0, 0, 0, 16'sd16384, 0, 0, 15'h7FFF);
        send_request(16'sd100, 16'sd200, -16'sd300, 16'sd5, -16'sd7, 16'sd9, 15'd1);
        send_request(16'hFFFF, 16'h5555, 16'hAAAA, 16'h0001, 16'hAAAA, 16'h5555,
                     15'h5555);
        send_request(0, 16'sd8192, 16'sd14189, 0, 0, 16'sd16384, 15'h2AAA);
        send_request(16'sd16384, 0, 0, 16'sd16384, 0, 0, 15'd4096);
        drain();

        // Phase 1: sender idles 31%, receiver 54%.
        send_idle_pct = 31;
        recv_idle_pct = 54;
        repeat (RANDOM_ITEMS / 3) send_random();

        // Long receiver hold-off while the sender keeps offering requests.
        recv_hold = 3 * LATENCY;
        repeat (120) send_random();
        drain();

        // Phase 2: swapped idle rates.
        send_idle_pct = 54;
        recv_idle_pct = 31;
        repeat (RANDOM_ITEMS / 3 - 120) send_random();

        // Phase 3: back to back.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (RANDOM_ITEMS / 3) send_random();
        go_idle();

        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);

        $display("Checked %0d results (%0d with total internal reflection), directed",
                 sb.checked, sb.tir_seen);
        $display("corner cases plus random angles, indices and backpressure.");
        if (sb.err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
